// ----- sv/indexed_list_engine_macros.svh -----
// ----------------------------------------------------------------------------
// indexed_list_engine_macros
// Assertion macros for the indexed list engine checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILST_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list engine check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ILST_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list engine check failed: next-cycle implication");

`endif

// ----- sv/ilst_pkg.sv -----
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared widths, operation and status codes, and the command and status
// structures that join the list engine controller and datapath.
// ----------------------------------------------------------------------------
package ilst_pkg;

	localparam int CAPACITY_DEF = 32;

	localparam int OP_W  = 3;
	localparam int POS_W = 6;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 6;

	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the request fields
		logic init_ptr;  // start the shift pointer
		logic shift_rd;  // read the neighbor of the pointer
		logic shift_wr;  // write the read data at the pointer and step it
		logic read_pos;  // read the slot at the requested position
		logic finish;    // commit the request and present its result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ok;    // the request passes all its checks
		logic            more;  // another shift step is needed
	} sts_t;

endpackage

// ----- sv/ilst_ram.sv -----
// ----------------------------------------------------------------------------
// ilst_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ilst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/ilst_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilst_ctrl
// Sequencer of the list engine: decodes a captured request and steps the
// datapath through slot shifts, reads and the final commit.
// ----------------------------------------------------------------------------
module ilst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ilst_pkg::sts_t sts,
	output ilst_pkg::cmd_t cmd,
	output logic          busy
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_DECODE   = 5'b00010,
		S_SHIFT_RD = 5'b00100,
		S_SHIFT_WR = 5'b01000,
		S_RD_WAIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.ok && sts.op == ilst_pkg::OP_READ) begin
					cmd.read_pos = 1'b1;
					state_d      = S_RD_WAIT;
				end else if (sts.ok && (sts.op == ilst_pkg::OP_INSERT ||
						sts.op == ilst_pkg::OP_REMOVE)) begin
					cmd.init_ptr = 1'b1;
					state_d      = S_SHIFT_RD;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SHIFT_RD: begin
				if (sts.more) begin
					cmd.shift_rd = 1'b1;
					state_d      = S_SHIFT_WR;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_RD_WAIT: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- sv/ilst_dp.sv -----
// ----------------------------------------------------------------------------
// ilst_dp
// Datapath of the list engine: request registers, live count, shift pointer,
// request checks, slot store and result registers.
// ----------------------------------------------------------------------------
module ilst_dp #(
	parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ilst_pkg::OP_W-1:0]         opcode,
	input  logic [ilst_pkg::POS_W-1:0]        position,
	input  logic signed [ilst_pkg::VAL_W-1:0] value,
	input  ilst_pkg::cmd_t                    cmd,
	output ilst_pkg::sts_t                    sts,
	output logic                              done,
	output logic signed [ilst_pkg::VAL_W-1:0] read_value,
	output logic [ilst_pkg::ST_W-1:0]         status,
	output logic [ilst_pkg::CNT_W-1:0]        count
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > ilst_pkg::POS_W) ? CW : ilst_pkg::POS_W;

	logic [ilst_pkg::OP_W-1:0]  op_q;
	logic [ilst_pkg::POS_W-1:0] pos_q;
	logic [ilst_pkg::VAL_W-1:0] val_q;
	logic [CW-1:0]              count_q;
	logic [CMPW-1:0]            ptr_q;
	logic                       done_q;
	logic [ilst_pkg::ST_W-1:0]  status_q;
	logic [ilst_pkg::VAL_W-1:0] rv_q;

	logic [CMPW-1:0]            pos_x;
	logic [CMPW-1:0]            cnt_x;
	logic [CMPW-1:0]            ptr_m1;
	logic [CMPW-1:0]            ptr_p1;
	logic [CMPW-1:0]            ptr_nb;
	logic                       full;
	logic                       is_ins;
	logic [ilst_pkg::ST_W-1:0]  st;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [ilst_pkg::VAL_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [ilst_pkg::VAL_W-1:0] ram_rdata;

	assign pos_x  = CMPW'(pos_q);
	assign cnt_x  = CMPW'(count_q);
	assign full   = (count_q == CW'(CAPACITY));
	assign is_ins = (op_q == ilst_pkg::OP_INSERT);
	assign ptr_m1 = ptr_q - CMPW'(1);
	assign ptr_p1 = ptr_q + CMPW'(1);
	// An insert moves entries up, so it reads below the pointer; a remove
	// moves them down and reads above it.
	assign ptr_nb = is_ins ? ptr_m1 : ptr_p1;

	always_comb begin
		st = ilst_pkg::ST_OK;
		unique case (op_q)
			ilst_pkg::OP_APPEND: begin
				if (full) begin
					st = ilst_pkg::ST_FULL;
				end
			end
			ilst_pkg::OP_POP: begin
				if (count_q == '0) begin
					st = ilst_pkg::ST_EMPTY;
				end
			end
			ilst_pkg::OP_INSERT: begin
				if (pos_x > cnt_x) begin
					st = ilst_pkg::ST_RANGE;
				end else if (full) begin
					st = ilst_pkg::ST_FULL;
				end
			end
			ilst_pkg::OP_REMOVE, ilst_pkg::OP_READ, ilst_pkg::OP_WRITE: begin
				if (pos_x >= cnt_x) begin
					st = ilst_pkg::ST_RANGE;
				end
			end
			default: begin
				st = ilst_pkg::ST_OK;
			end
		endcase
	end

	assign sts.op   = op_q;
	assign sts.ok   = (st == ilst_pkg::ST_OK);
	assign sts.more = is_ins ? (ptr_q > pos_x) : (ptr_p1 < cnt_x);

	assign ram_re    = cmd.read_pos | cmd.shift_rd;
	assign ram_raddr = cmd.read_pos ? pos_x[AW-1:0] : ptr_nb[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_x[AW-1:0];
		ram_wdata = val_q;
		if (cmd.shift_wr) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q[AW-1:0];
			ram_wdata = ram_rdata;
		end else if (cmd.finish && sts.ok) begin
			if (op_q == ilst_pkg::OP_APPEND) begin
				ram_we    = 1'b1;
				ram_waddr = cnt_x[AW-1:0];
			end else if (op_q == ilst_pkg::OP_INSERT || op_q == ilst_pkg::OP_WRITE) begin
				ram_we = 1'b1;
			end
		end
	end

	ilst_ram #(
		.WIDTH(ilst_pkg::VAL_W),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish && sts.ok) begin
				if (op_q == ilst_pkg::OP_APPEND || op_q == ilst_pkg::OP_INSERT) begin
					count_q <= count_q + CW'(1);
				end else if (op_q == ilst_pkg::OP_POP || op_q == ilst_pkg::OP_REMOVE) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.init_ptr) begin
			ptr_q <= is_ins ? cnt_x : pos_x;
		end else if (cmd.shift_wr) begin
			ptr_q <= ptr_nb;
		end
		if (cmd.finish) begin
			status_q <= st;
			if (op_q == ilst_pkg::OP_READ) begin
				rv_q <= sts.ok ? ram_rdata : {ilst_pkg::VAL_W{1'b1}};
			end else begin
				rv_q <= '0;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = rv_q;
	assign count      = cnt_x[ilst_pkg::CNT_W-1:0];

endmodule

// ----- sv/indexed_list_engine.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of signed 32-bit values with append, pop, insert,
// remove, read and overwrite by position.
// ----------------------------------------------------------------------------
// A request is taken as one beat at a rising edge where start is high and
// busy is low; its single result beat appears on read_value, status and count
// for exactly one cycle while done is high, and the receiver must take it
// then, since nothing can hold it off. Append, pop, overwrite and every
// request that fails its checks go from the decode state straight to the
// commit, and busy drops in the same cycle that done rises, so a new
// request can be accepted while the previous result is on the ports. A
// read waits in an extra state because the slot store has a registered
// read port. Insert and remove shift the later entries one slot at a
// time through that same store, one read and one write per step, in m
// steps, where m is count minus position for an insert and count minus
// position minus one for a remove; a full-length shift on a list of
// CAPACITY entries is the slowest case. The count port always shows
// the live count (low six bits), and during the done cycle it is the count
// after that request. Status codes: ok, position out of range, store full,
// list empty. A failed read returns -1; read_value is 0 for all other
// operations. Opcodes six and seven are accepted, change nothing and report
// ok. The slot store needs no clearing after reset, because only slots below
// the count are ever read and each of those has been written.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
	parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ilst_pkg::OP_W-1:0]         opcode,
	input  logic [ilst_pkg::POS_W-1:0]        position,
	input  logic signed [ilst_pkg::VAL_W-1:0] value,
	output logic                              done,
	output logic signed [ilst_pkg::VAL_W-1:0] read_value,
	output logic [ilst_pkg::ST_W-1:0]         status,
	output logic [ilst_pkg::CNT_W-1:0]        count
);

	// The controller and the datapath talk only through these two bundles.
	ilst_pkg::cmd_t cmd;
	ilst_pkg::sts_t sts;

	// The controller sequences each request: decode, optional shift loop or
	// store read, and one commit step that updates the count and the result.
	ilst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	// The datapath holds the captured request, the count, the shift pointer,
	// the slot store and the registered result.
	ilst_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.opcode    (opcode),
		.position  (position),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.read_value(read_value),
		.status    (status),
		.count     (count)
	);

endmodule

// ----- sv/ilst_checker.sv -----
// ----------------------------------------------------------------------------
// ilst_checker
// Port-level checks of the list engine handshake and results, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_macros.svh"

module ilst_checker #(
	parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [ilst_pkg::ST_W-1:0]         status,
	input logic [ilst_pkg::CNT_W-1:0]        count
);

	logic accept;
	assign accept = start && !busy;

	// An accepted request always occupies the engine in the following cycle.
	`ILST_ASSERT_NXT(a_accept_busy, accept, busy)
	// A result is presented only once the engine is free again.
	`ILST_ASSERT_IMP(a_done_idle, done, !busy)
	// Every end of a busy period delivers exactly one result.
	`ILST_ASSERT_IMP(a_fall_done, $fell(busy), done)
	// A pop refused as empty leaves an empty list.
	`ILST_ASSERT_IMP(a_empty_zero, done && (status == ilst_pkg::ST_EMPTY), count == '0)
	// The count never exceeds the store size.
	`ILST_ASSERT_IMP(a_count_cap, done && (CAPACITY < 64), 32'(count) <= CAPACITY)

endmodule

bind indexed_list_engine ilst_checker #(.CAPACITY(CAPACITY)) u_ilst_checker (.*);
